[src/skj_pkg.sv]
// Shared types, constants and the quaternion term table for the joint composer.
// Used by skj_mac and skeleton_joint_hierarchy_compose_core.
package skj_pkg;

    localparam int SKJ_MAX_JOINTS = 256;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROT,
        ST_ROT_WAIT,
        ST_LOC,
        ST_LOC_WAIT,
        ST_MUL,
        ST_MUL_WAIT,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_ROT,
        PH_LOC,
        PH_MUL
    } t_phase;

    typedef struct packed {
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] rot_w;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic [15:0]        parent_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         joint_index;
        logic [1:0]         row_index;
        logic signed [31:0] elem_0;
        logic signed [31:0] elem_1;
        logic signed [31:0] elem_2;
        logic signed [31:0] elem_3;
        logic               last_row;
        logic               last_joint;
    } t_out_item;

    // one multiply term in flight
    typedef struct packed {
        t_phase     phase;
        logic [3:0] i;
        logic [1:0] j;
        logic [1:0] k;
    } t_term;

    // accumulate control that rides with a product
    typedef struct packed {
        logic       first;
        logic       last;
        logic       w2;
        logic       neg;
        logic       base_one;
        t_phase     phase;
        logic [3:0] dest;
    } t_mac_ctl;

    // rotation entry: one - 2(a*a + c*c) when one is set, else 2(a*b +/- c*d)
    typedef struct packed {
        logic       one;
        logic [1:0] a;
        logic [1:0] b;
        logic [1:0] c;
        logic [1:0] d;
        logic       neg;
    } t_rot_term;

    function automatic t_rot_term rot_term(input logic [3:0] idx);
        t_rot_term r;
        case (idx)
            4'd0:    r = '{one: 1'b1, a: 2'd1, b: 2'd1, c: 2'd2, d: 2'd2, neg: 1'b0};
            4'd1:    r = '{one: 1'b0, a: 2'd0, b: 2'd1, c: 2'd2, d: 2'd3, neg: 1'b0};
            4'd2:    r = '{one: 1'b0, a: 2'd0, b: 2'd2, c: 2'd1, d: 2'd3, neg: 1'b1};
            4'd3:    r = '{one: 1'b0, a: 2'd0, b: 2'd1, c: 2'd2, d: 2'd3, neg: 1'b1};
            4'd4:    r = '{one: 1'b1, a: 2'd0, b: 2'd0, c: 2'd2, d: 2'd2, neg: 1'b0};
            4'd5:    r = '{one: 1'b0, a: 2'd1, b: 2'd2, c: 2'd0, d: 2'd3, neg: 1'b0};
            4'd6:    r = '{one: 1'b0, a: 2'd0, b: 2'd2, c: 2'd1, d: 2'd3, neg: 1'b0};
            4'd7:    r = '{one: 1'b0, a: 2'd1, b: 2'd2, c: 2'd0, d: 2'd3, neg: 1'b1};
            4'd8:    r = '{one: 1'b1, a: 2'd0, b: 2'd0, c: 2'd1, d: 2'd1, neg: 1'b0};
            default: r = '{one: 1'b0, a: 2'd0, b: 2'd0, c: 2'd0, d: 2'd0, neg: 1'b0};
        endcase
        return r;
    endfunction

endpackage

[src/skj_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/skj_mac.sv]
// Shared 32x32 signed multiplier with exact wide accumulator, rounding and saturation.
// Depends on skj_pkg.
module skj_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [31:0] i_op_a,
    input  logic signed [31:0] i_op_b,
    input  skj_pkg::t_mac_ctl  i_ctl,
    output logic               o_busy,
    output logic               o_done,
    output skj_pkg::t_phase    o_phase,
    output logic [3:0]         o_dest,
    output logic signed [31:0] o_value
);
    import skj_pkg::*;

    logic               r_pv;
    logic signed [63:0] r_prod;
    t_mac_ctl           r_pctl;
    logic               r_av;
    logic signed [71:0] r_acc;
    t_mac_ctl           r_actl;

    logic signed [71:0] w_ext;
    logic signed [71:0] w_term;
    logic signed [71:0] w_base;
    logic signed [71:0] n_acc;
    logic signed [71:0] w_rsum;
    logic signed [71:0] w_rsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_av <= 1'b0;
        end else begin
            r_pv <= i_valid;
            r_av <= r_pv;
        end
        r_prod <= i_op_a * i_op_b;
        r_pctl <= i_ctl;
        if (r_pv) begin
            r_acc <= n_acc;
        end
        r_actl <= r_pctl;
    end

    always_comb begin
        w_ext  = 72'(r_prod);
        w_term = r_pctl.w2 ? (w_ext <<< 1) : w_ext;
        if (r_pctl.neg) begin
            w_term = -w_term;
        end
        w_base = r_pctl.base_one ? (72'sd1 <<< 32) : 72'sd0;
        n_acc  = (r_pctl.first ? w_base : r_acc) + w_term;
    end

    // round half up, then clamp to 32 bits
    always_comb begin
        w_rsum = r_acc + 72'sd32768;
        w_rsh  = w_rsum >>> 16;
        if (w_rsh > 72'sd2147483647) begin
            o_value = 32'sh7FFFFFFF;
        end else if (w_rsh < -72'sd2147483648) begin
            o_value = 32'sh80000000;
        end else begin
            o_value = w_rsh[31:0];
        end
    end

    assign o_busy  = r_pv | r_av;
    assign o_done  = r_av & r_actl.last;
    assign o_phase = r_actl.phase;
    assign o_dest  = r_actl.dest;

endmodule

[src/skeleton_joint_hierarchy_compose_core.sv]
// Joint hierarchy composer: local TRS matrix times stored parent model matrix.
// Depends on skj_pkg, skj_ram and skj_mac.
//
// One joint per input transfer, four row transfers out. All products go through one
// shared 32x32 multiplier under a sequencer: 18 rotation terms, 9 scale terms and,
// when the parent index is below the joint count, 64 parent-product terms, each phase
// followed by a drain of the multiplier pipeline, then the matrix is written to the
// store; no new joint is taken until its last row is out. After reset the matrix
// store is cleared, during which no joint is taken.
module skeleton_joint_hierarchy_compose_core #(
    parameter int MAX_JOINTS = skj_pkg::SKJ_MAX_JOINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  skj_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output skj_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_data
);
    import skj_pkg::*;

    localparam int DEPTH = MAX_JOINTS * 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int NCAP  = (MAX_JOINTS < 256) ? MAX_JOINTS : 256;

    t_state r_state, n_state;

    logic [8:0]         r_jcount;
    logic [7:0]         r_jc;
    logic [7:0]         r_self;
    logic [7:0]         r_par;
    logic               r_has_par;
    logic               r_last;
    logic [AW-1:0]      r_clr;
    logic [3:0]         r_i;
    logic [1:0]         r_j;
    logic [1:0]         r_k;
    logic [3:0]         r_wc;
    logic [1:0]         r_row;
    logic               r_s1v;
    t_term              r_s1;

    logic signed [31:0] r_s   [3];
    logic signed [31:0] r_q   [4];
    logic signed [31:0] r_rot [9];
    logic signed [31:0] r_loc [16];
    logic signed [31:0] r_res [16];

    logic               w_accept;
    logic               w_out_xfer;
    logic               w_issue;
    logic               w_drained;
    logic               w_rot_end, w_loc_end, w_mul_end;
    logic [8:0]         w_n;
    logic [7:0]         w_self;
    t_term              w_term;
    t_rot_term          w_rt;
    logic [3:0]         w_ri;
    logic signed [31:0] w_op_a, w_op_b;
    t_mac_ctl           w_ctl;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [31:0]        w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [31:0]        w_rdata;

    logic               w_done;
    t_phase             w_done_phase;
    logic [3:0]         w_done_dest;
    logic signed [31:0] w_done_value;
    logic               w_busy;

    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_out_xfer = o_out_valid & ~i_out_stall;
    assign w_issue    = (r_state == ST_ROT) | (r_state == ST_LOC) | (r_state == ST_MUL);
    assign w_drained  = ~r_s1v & ~w_busy;
    assign w_rot_end  = (r_i == 4'd8) & (r_k == 2'd1);
    assign w_loc_end  = (r_i == 4'd2) & (r_j == 2'd2);
    assign w_mul_end  = (r_i == 4'd3) & (r_j == 2'd3) & (r_k == 2'd3);

    always_comb begin
        if (r_jcount == 9'd0) begin
            w_n = 9'd1;
        end else if (r_jcount > 9'(NCAP)) begin
            w_n = 9'(NCAP);
        end else begin
            w_n = r_jcount;
        end
        w_self = (int'(r_jc) >= MAX_JOINTS) ? 8'd0 : r_jc;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:     if (w_accept) n_state = ST_ROT;
            ST_ROT:      if (w_rot_end) n_state = ST_ROT_WAIT;
            ST_ROT_WAIT: if (w_drained) n_state = ST_LOC;
            ST_LOC:      if (w_loc_end) n_state = ST_LOC_WAIT;
            ST_LOC_WAIT: if (w_drained) n_state = r_has_par ? ST_MUL : ST_WRITE;
            ST_MUL:      if (w_mul_end) n_state = ST_MUL_WAIT;
            ST_MUL_WAIT: if (w_drained) n_state = ST_WRITE;
            ST_WRITE:    if (r_wc == 4'd15) n_state = ST_OUT;
            ST_OUT:      if (w_out_xfer && r_row == 2'd3) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        o_cfg_ready = 1'b1;
        o_out_item.joint_index = r_self;
        o_out_item.row_index   = r_row;
        o_out_item.elem_0      = r_res[{r_row, 2'd0}];
        o_out_item.elem_1      = r_res[{r_row, 2'd1}];
        o_out_item.elem_2      = r_res[{r_row, 2'd2}];
        o_out_item.elem_3      = r_res[{r_row, 2'd3}];
        o_out_item.last_row    = (r_row == 2'd3);
        o_out_item.last_joint  = r_last;
    end

    always_comb begin
        w_term.i = r_i;
        w_term.j = r_j;
        w_term.k = r_k;
        case (r_state)
            ST_LOC:  w_term.phase = PH_LOC;
            ST_MUL:  w_term.phase = PH_MUL;
            default: w_term.phase = PH_ROT;
        endcase
    end

    // operand select for the term in stage 1
    always_comb begin
        w_rt   = rot_term(r_s1.i);
        w_ri   = (r_s1.i << 1) + r_s1.i + 4'(r_s1.j);
        w_op_a = '0;
        w_op_b = '0;
        w_ctl  = '{first: 1'b1, last: 1'b1, w2: 1'b0, neg: 1'b0, base_one: 1'b0,
                   phase: r_s1.phase, dest: 4'd0};
        case (r_s1.phase)
            PH_ROT: begin
                if (r_s1.k == 2'd0) begin
                    w_op_a = r_q[w_rt.a];
                    w_op_b = r_q[w_rt.one ? w_rt.a : w_rt.b];
                end else begin
                    w_op_a = r_q[w_rt.c];
                    w_op_b = r_q[w_rt.one ? w_rt.c : w_rt.d];
                end
                w_ctl.first    = (r_s1.k == 2'd0);
                w_ctl.last     = (r_s1.k == 2'd1);
                w_ctl.w2       = 1'b1;
                w_ctl.neg      = w_rt.one | ((r_s1.k == 2'd1) & w_rt.neg);
                w_ctl.base_one = w_rt.one;
                w_ctl.dest     = r_s1.i;
            end
            PH_LOC: begin
                w_op_a     = r_s[r_s1.i[1:0]];
                w_op_b     = r_rot[w_ri];
                w_ctl.dest = {r_s1.i[1:0], r_s1.j};
            end
            PH_MUL: begin
                w_op_a      = r_loc[{r_s1.i[1:0], r_s1.k}];
                w_op_b      = w_rdata;
                w_ctl.first = (r_s1.k == 2'd0);
                w_ctl.last  = (r_s1.k == 2'd3);
                w_ctl.dest  = {r_s1.i[1:0], r_s1.j};
            end
            default: ;
        endcase
    end

    skj_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1v),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .i_ctl   (w_ctl),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_phase (w_done_phase),
        .o_dest  (w_done_dest),
        .o_value (w_done_value)
    );

    assign w_we    = (r_state == ST_CLEAR) | (r_state == ST_WRITE);
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr : AW'({r_self, r_wc});
    assign w_wdata = (r_state == ST_CLEAR) ? 32'd0 : r_res[r_wc];
    assign w_raddr = AW'({r_par, r_k, r_j});

    skj_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_jcount <= 9'd1;
            r_jc     <= 8'd0;
            r_clr    <= '0;
            r_i      <= 4'd0;
            r_j      <= 2'd0;
            r_k      <= 2'd0;
            r_wc     <= 4'd0;
            r_row    <= 2'd0;
            r_s1v    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1v   <= w_issue;
            if (i_cfg_valid && o_cfg_ready) begin
                r_jcount <= i_cfg_data;
            end
            case (r_state)
                ST_CLEAR: r_clr <= r_clr + AW'(1);
                ST_ROT: begin
                    if (r_k == 2'd1) begin
                        r_k <= 2'd0;
                        r_i <= w_rot_end ? 4'd0 : r_i + 4'd1;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                ST_LOC: begin
                    if (r_j == 2'd2) begin
                        r_j <= 2'd0;
                        r_i <= w_loc_end ? 4'd0 : r_i + 4'd1;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                ST_MUL: begin
                    {r_i, r_j, r_k} <= w_mul_end ? 8'd0 : {r_i, r_j, r_k} + 8'd1;
                end
                ST_WRITE: r_wc <= r_wc + 4'd1;
                ST_OUT: begin
                    if (w_out_xfer) begin
                        r_row <= r_row + 2'd1;
                        if (r_row == 2'd3) begin
                            r_jc <= r_last ? 8'd0 : r_self + 8'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1 <= w_term;
        if (w_accept) begin
            r_s[0]    <= i_in_item.scale_x;
            r_s[1]    <= i_in_item.scale_y;
            r_s[2]    <= i_in_item.scale_z;
            r_q[0]    <= i_in_item.rot_x;
            r_q[1]    <= i_in_item.rot_y;
            r_q[2]    <= i_in_item.rot_z;
            r_q[3]    <= i_in_item.rot_w;
            r_loc[3]  <= '0;
            r_loc[7]  <= '0;
            r_loc[11] <= '0;
            r_loc[12] <= i_in_item.trans_x;
            r_loc[13] <= i_in_item.trans_y;
            r_loc[14] <= i_in_item.trans_z;
            r_loc[15] <= 32'sh00010000;
            r_self    <= w_self;
            r_par     <= i_in_item.parent_index[7:0];
            r_has_par <= (i_in_item.parent_index < 16'(w_n));
            r_last    <= ({1'b0, w_self} + 9'd1) >= w_n;
        end
        if (w_done) begin
            case (w_done_phase)
                PH_ROT:  r_rot[w_done_dest] <= w_done_value;
                PH_LOC:  r_loc[w_done_dest] <= w_done_value;
                PH_MUL:  r_res[w_done_dest] <= w_done_value;
                default: ;
            endcase
        end
        // root joint: the model matrix is the local matrix
        if (r_state == ST_LOC_WAIT && w_drained && !r_has_par) begin
            r_res <= r_loc;
        end
    end

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input taken while a joint is in work");

    a_no_out_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("row offered while input side is open");

    a_last_row_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_out_item.last_row) |=> !o_out_valid)
        else $error("rows continue after the last row transfer");

    a_mac_idle_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!w_busy && !r_s1v))
        else $error("multiply pipeline active during output");

endmodule
